/* rtl/mfb_pkg.sv */
package mfb_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

    // Frame size registers.
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1024;
    localparam int HEIGHT_LIMIT = 4096;

    // Datapath widths.
    localparam int PIX_W  = 8;
    localparam int ROW_W  = 13;
    localparam int SUM_W  = 12;
    localparam int CNT_W  = 4;
    localparam int Q3_W   = 10;
    localparam int KSIZE  = 3;

    // floor(s / 3) = (s * 2731) >> 13 holds exactly for every s below 4096.
    localparam int DIV3_MUL   = 2731;
    localparam int DIV3_SHIFT = 13;
    localparam int PROD_W     = 24;

    typedef struct packed {
        logic take;
        logic shift;
        logic sum;
        logic div1;
        logic load_out;
    } mfb_cmd_t;

    typedef struct packed {
        logic receiving;
        logic primed;
    } mfb_stat_t;

endpackage

/* rtl/mean_filter_3x3_border.sv */
// A taken request reads the line stores; one that yields a result then passes through window
// shift, neighbourhood sum and two divide-by-three steps; its result is loaded when the output
// is free. A request without a result returns to idle after the window shift; a dropped early
// drain does not leave idle. A new request is taken only once the sequencer is back in idle.
// Reset clears the sequencer, counters and window and sets both size registers to 1024;
// the line stores are not cleared and need no clearing pass.
module mean_filter_3x3_border
    import mfb_pkg::*;
    #(
        parameter int MAX_WIDTH = 1024
    )
    (
        input  logic                  clk,
        input  logic                  rst_n,
        input  logic                  cfg_valid,
        output logic                  cfg_ready,
        input  logic [CFG_IDX_W-1:0]  cfg_index,
        input  logic [CFG_DATA_W-1:0] cfg_data,
        input  logic                  in_valid,
        output logic                  in_ready,
        input  logic                  mode,
        input  logic [PIX_W-1:0]      pixel_in,
        output logic                  out_valid,
        input  logic                  out_ready,
        output logic [PIX_W-1:0]      pixel_out,
        output logic                  end_of_frame
    );

    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    mfb_cmd_t            cmd;
    mfb_stat_t           stat;

    mfb_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .w_eff     (w_eff),
        .h_eff     (h_eff)
    );

    mfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mfb_dpath #(.MAX_WIDTH(MAX_WIDTH)) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .w_eff        (w_eff),
        .h_eff        (h_eff),
        .pixel_in     (pixel_in),
        .pixel_out    (pixel_out),
        .end_of_frame (end_of_frame)
    );

`ifndef ASSERT_OFF
    // The sequencer is in exactly one of its working steps, or idle.
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({in_ready, cmd.shift, cmd.sum, cmd.div1}))
        else $error("sequencer steps overlap");

    // A taken request always goes on to update the window in the next cycle.
    a_take_shift: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> cmd.shift)
        else $error("window update missing after request");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("result register overwritten");

    // The divide step always follows the sum step.
    a_sum_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum |=> cmd.div1)
        else $error("divide step missing after sum");
`endif

endmodule

/* rtl/mfb_ram.sv */
module mfb_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 1024,
        localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic             clk,
        input  logic             we,
        input  logic [AW-1:0]    waddr,
        input  logic [WIDTH-1:0] wdata,
        input  logic             re,
        input  logic [AW-1:0]    raddr,
        output logic [WIDTH-1:0] rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/mfb_cfg.sv */
module mfb_cfg
    import mfb_pkg::*;
    #(
        parameter int MAX_WIDTH = 1024
    )
    (
        input  logic                  clk,
        input  logic                  rst_n,
        input  logic                  cfg_valid,
        output logic                  cfg_ready,
        input  logic [CFG_IDX_W-1:0]  cfg_index,
        input  logic [CFG_DATA_W-1:0] cfg_data,
        output logic [WIDTH_W-1:0]    w_eff,
        output logic [HEIGHT_W-1:0]   h_eff
    );

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Out-of-range sizes behave as the nearest legal size.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WIDTH_W'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end

        if (height_reg == '0)
        begin
            h_eff = HEIGHT_W'(1);
        end
        else if (32'(height_reg) > HEIGHT_LIMIT)
        begin
            h_eff = HEIGHT_W'(HEIGHT_LIMIT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

endmodule

/* rtl/mfb_ctrl.sv */
module mfb_ctrl
    import mfb_pkg::*;
    (
        input  logic      clk,
        input  logic      rst_n,
        input  logic      in_valid,
        output logic      in_ready,
        input  logic      mode,
        output logic      out_valid,
        input  logic      out_ready,
        input  mfb_stat_t stat,
        output mfb_cmd_t  cmd
    );

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHIFT = 3'd1;
    localparam logic [2:0] ST_SUM   = 3'd2;
    localparam logic [2:0] ST_DIV1  = 3'd3;
    localparam logic [2:0] ST_DIV2  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                // A drain request while the frame is still arriving is dropped.
                if (in_valid && !(mode && stat.receiving))
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = stat.primed ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                cmd.div1   = 1'b1;
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/mfb_dpath.sv */
module mfb_dpath
    import mfb_pkg::*;
    #(
        parameter int MAX_WIDTH = 1024,
        localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
    )
    (
        input  logic                clk,
        input  logic                rst_n,
        input  mfb_cmd_t            cmd,
        output mfb_stat_t           stat,
        input  logic [WIDTH_W-1:0]  w_eff,
        input  logic [HEIGHT_W-1:0] h_eff,
        input  logic [PIX_W-1:0]    pixel_in,
        output logic [PIX_W-1:0]    pixel_out,
        output logic                end_of_frame
    );

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    logic [PIX_W-1:0] win_reg [KSIZE*KSIZE];
    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] upper_rd;
    logic [PIX_W-1:0] middle_rd;

    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             eof_reg;
    logic [Q3_W-1:0]  q3_reg;
    logic [PIX_W-1:0] pixel_out_reg;
    logic             end_of_frame_reg;

    logic [KSIZE-1:0] row_ok;
    logic [KSIZE-1:0] col_ok;
    logic [SUM_W-1:0] row_sum [KSIZE];
    logic [SUM_W-1:0] sum_c;
    logic [1:0]       rows_n;
    logic [1:0]       cols_n;
    logic             last;
    logic [PROD_W-1:0] prod_a;
    logic [PROD_W-1:0] prod_b;
    logic [PIX_W-1:0] result;

    // Line stores: the upper one holds row r-2, the middle one row r-1.
    mfb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk   (clk),
        .we    (cmd.shift),
        .waddr (in_col_reg),
        .wdata (middle_rd),
        .re    (cmd.take),
        .raddr (in_col_reg),
        .rdata (upper_rd)
    );

    mfb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .clk   (clk),
        .we    (cmd.shift),
        .waddr (in_col_reg),
        .wdata (pix_reg),
        .re    (cmd.take),
        .raddr (in_col_reg),
        .rdata (middle_rd)
    );

    assign stat.receiving = 32'(in_row_reg) < 32'(h_eff);
    assign stat.primed    = (32'(in_row_reg) >= 32'd2) ||
                            ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));

    assign last = (32'(out_row_reg) + 32'd1 >= 32'(h_eff)) &&
                  (32'(out_col_reg) + 32'd1 >= 32'(w_eff));

    // Which window rows and columns lie inside the frame.
    always_comb
    begin
        row_ok[0] = (out_row_reg != '0) && (32'(out_row_reg) <= 32'(h_eff));
        row_ok[1] = 32'(out_row_reg) < 32'(h_eff);
        row_ok[2] = 32'(out_row_reg) + 32'd1 < 32'(h_eff);
        col_ok[0] = (out_col_reg != '0) && (32'(out_col_reg) <= 32'(w_eff));
        col_ok[1] = 32'(out_col_reg) < 32'(w_eff);
        col_ok[2] = 32'(out_col_reg) + 32'd1 < 32'(w_eff);
    end

    always_comb
    begin
        for (int k = 0; k < KSIZE; k++)
        begin
            row_sum[k] = '0;
            for (int l = 0; l < KSIZE; l++)
            begin
                if (row_ok[k] && col_ok[l])
                begin
                    row_sum[k] = row_sum[k] + SUM_W'(win_reg[KSIZE*k+l]);
                end
            end
        end
        sum_c  = row_sum[0] + row_sum[1] + row_sum[2];
        rows_n = {1'b0, row_ok[0]} + {1'b0, row_ok[1]} + {1'b0, row_ok[2]};
        cols_n = {1'b0, col_ok[0]} + {1'b0, col_ok[1]} + {1'b0, col_ok[2]};
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cmd.shift)
        begin
            if (32'(in_col_reg) + 32'd1 >= 32'(w_eff))
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end
        if (cmd.sum)
        begin
            if (last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else if (32'(out_col_reg) + 32'd1 >= 32'(w_eff))
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + ROW_W'(1);
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            for (int i = 0; i < KSIZE*KSIZE; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            if (cmd.shift)
            begin
                for (int k = 0; k < KSIZE; k++)
                begin
                    win_reg[KSIZE*k]   <= win_reg[KSIZE*k+1];
                    win_reg[KSIZE*k+1] <= win_reg[KSIZE*k+2];
                end
                win_reg[2] <= upper_rd;
                win_reg[5] <= middle_rd;
                win_reg[8] <= pix_reg;
            end
        end
    end

    // Divide by three with a reciprocal; six and nine reuse the first quotient.
    assign prod_a = PROD_W'(sum_reg) * PROD_W'(DIV3_MUL);
    assign prod_b = PROD_W'(q3_reg) * PROD_W'(DIV3_MUL);

    always_comb
    begin
        case (cnt_reg)
            CNT_W'(1): result = sum_reg[PIX_W-1:0];
            CNT_W'(2): result = sum_reg[PIX_W:1];
            CNT_W'(3): result = q3_reg[PIX_W-1:0];
            CNT_W'(4): result = sum_reg[PIX_W+1:2];
            CNT_W'(6): result = q3_reg[PIX_W:1];
            CNT_W'(9): result = prod_b[DIV3_SHIFT+PIX_W-1:DIV3_SHIFT];
            default:   result = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            // Past the last row the window is fed with zeros.
            pix_reg <= stat.receiving ? pixel_in : '0;
        end
        if (cmd.sum)
        begin
            sum_reg <= sum_c;
            cnt_reg <= CNT_W'(rows_n) * CNT_W'(cols_n);
            eof_reg <= last;
        end
        if (cmd.div1)
        begin
            q3_reg <= prod_a[DIV3_SHIFT+Q3_W-1:DIV3_SHIFT];
        end
        if (cmd.load_out)
        begin
            pixel_out_reg    <= result;
            end_of_frame_reg <= eof_reg;
        end
    end

    assign pixel_out    = pixel_out_reg;
    assign end_of_frame = end_of_frame_reg;

endmodule
